@@ rtl/bssa_pkg.sv @@
// Shared codes and types for the bounded set store.
package bssa_pkg;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_UNION  = 3'd2;
  localparam logic [2:0] ACT_INTER  = 3'd3;
  localparam logic [2:0] ACT_DIFF   = 3'd4;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_PRESENT  = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    MEM_A,
    MEM_B,
    MEM_S
  } mem_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_INS_DONE,
    S_DEL_DONE,
    S_DEL_WR,
    S_RESP,
    S_CPY_RD,
    S_CPY_WR,
    S_OUTER_RD,
    S_OUTER_KEY,
    S_OUTER_DONE,
    S_DIF_DONE,
    S_DIF_WR,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

endpackage

@@ rtl/bssa_ram.sv @@
// Single-write, single-read element store with registered read data.
module bssa_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the last word read while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/bounded_set_store_with_algebra.sv @@
// Top level of the bounded set store: two sets, a scratch set and a search sequencer.
//
//   channel   direction  handshake              fields
//   request   in         req_valid / req_stall  action, set_select, element_value
//   response  out        rsp_valid / rsp_stall  result_value, result_valid, last,
//                                               status, result_count
//
// A request is taken only while the sequencer is idle. Each stored entry looked at
// passes a read state, then a compare state, on the one shared comparator; delete
// and a non-full insert scan the chosen set, and the set algebra searches one set
// per element of the other, plus copy and output (difference also searches scratch).
// Reset (rst, synchronous) empties both sets; element memories are not cleared.
// A stalled response beat holds in the output register; the sequencer waits on it
// only when it has a new beat to present, so the next request may be taken meanwhile.
module bounded_set_store_with_algebra #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         action,
  input  logic               set_select,
  input  logic signed [31:0] element_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] result_value,
  output logic               result_valid,
  output logic               last,
  output logic [1:0]         status,
  output logic [4:0]         result_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  bssa_pkg::state_t st, st_next, ret, ret_next;
  bssa_pkg::mem_t   srch_mem, srch_mem_next, rd_mem, rd_mem_next;
  bssa_pkg::mem_t   rd_sel, wr_sel, sel_mem;

  logic [2:0]    op, op_next;
  logic          sel, sel_next;
  logic [31:0]   key, key_next;
  logic [CW-1:0] i, i_next, j, j_next, pos, pos_next, srch_n, srch_n_next;
  logic [CW-1:0] cnt_a, cnt_a_next, cnt_b, cnt_b_next, sc, sc_next;
  logic [CW-1:0] cnt_sel, cnt_in, lim;
  logic          found, found_next;
  logic [1:0]    stat, stat_next;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data, rd_data, a_q, b_q, s_q;

  logic          out_free, o_load, o_valid, o_last;
  logic [31:0]   o_value;
  logic [1:0]    o_status;
  logic [4:0]    o_count;

  bssa_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram_a (
    .clk(clk), .wr_en(wr_en && wr_sel == bssa_pkg::MEM_A), .wr_addr(wr_addr),
    .wr_data(wr_data), .rd_en(rd_en && rd_sel == bssa_pkg::MEM_A), .rd_addr(rd_addr),
    .rd_data(a_q)
  );

  bssa_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram_b (
    .clk(clk), .wr_en(wr_en && wr_sel == bssa_pkg::MEM_B), .wr_addr(wr_addr),
    .wr_data(wr_data), .rd_en(rd_en && rd_sel == bssa_pkg::MEM_B), .rd_addr(rd_addr),
    .rd_data(b_q)
  );

  bssa_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram_s (
    .clk(clk), .wr_en(wr_en && wr_sel == bssa_pkg::MEM_S), .wr_addr(wr_addr),
    .wr_data(wr_data), .rd_en(rd_en && rd_sel == bssa_pkg::MEM_S), .rd_addr(rd_addr),
    .rd_data(s_q)
  );

  // route the read data of whichever store was last read
  always_comb begin
    unique case (rd_mem)
      bssa_pkg::MEM_A: rd_data = a_q;
      bssa_pkg::MEM_B: rd_data = b_q;
      default:         rd_data = s_q;
    endcase
  end

  assign sel_mem   = sel ? bssa_pkg::MEM_B : bssa_pkg::MEM_A;
  assign cnt_sel   = sel ? cnt_b : cnt_a;
  assign cnt_in    = set_select ? cnt_b : cnt_a;
  assign lim       = (op == bssa_pkg::ACT_UNION) ? cnt_b : cnt_a;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (st != bssa_pkg::S_IDLE);

  always_comb begin
    st_next       = st;
    ret_next      = ret;
    srch_mem_next = srch_mem;
    op_next       = op;
    sel_next      = sel;
    key_next      = key;
    i_next        = i;
    j_next        = j;
    pos_next      = pos;
    srch_n_next   = srch_n;
    cnt_a_next    = cnt_a;
    cnt_b_next    = cnt_b;
    sc_next       = sc;
    found_next    = found;
    stat_next     = stat;
    rd_en         = 1'b0;
    rd_sel        = bssa_pkg::MEM_A;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_sel        = bssa_pkg::MEM_A;
    wr_addr       = '0;
    wr_data       = key;
    o_load        = 1'b0;
    o_value       = '0;
    o_valid       = 1'b0;
    o_last        = 1'b1;
    o_status      = bssa_pkg::STAT_DONE;
    o_count       = '0;

    unique case (st)
      bssa_pkg::S_IDLE: begin
        if (req_valid) begin
          op_next       = action;
          sel_next      = set_select;
          key_next      = element_value;
          i_next        = '0;
          j_next        = '0;
          sc_next       = '0;
          srch_mem_next = set_select ? bssa_pkg::MEM_B : bssa_pkg::MEM_A;
          srch_n_next   = cnt_in;
          if (action == bssa_pkg::ACT_INSERT) begin
            if (cnt_in >= CAP) begin
              stat_next = bssa_pkg::STAT_FULL;
              st_next   = bssa_pkg::S_RESP;
            end else begin
              ret_next = bssa_pkg::S_INS_DONE;
              st_next  = bssa_pkg::S_SRCH_RD;
            end
          end else if (action == bssa_pkg::ACT_DELETE) begin
            ret_next = bssa_pkg::S_DEL_DONE;
            st_next  = bssa_pkg::S_SRCH_RD;
          end else if (action == bssa_pkg::ACT_UNION || action == bssa_pkg::ACT_DIFF) begin
            st_next = bssa_pkg::S_CPY_RD;
          end else if (action == bssa_pkg::ACT_INTER) begin
            st_next = bssa_pkg::S_OUTER_RD;
          end
        end
      end
      bssa_pkg::S_SRCH_RD: begin
        if (j >= srch_n) begin
          found_next = 1'b0;
          st_next    = ret;
        end else begin
          rd_en   = 1'b1;
          rd_sel  = srch_mem;
          rd_addr = j[AW-1:0];
          st_next = bssa_pkg::S_SRCH_CMP;
        end
      end
      bssa_pkg::S_SRCH_CMP: begin
        if (rd_data == key) begin
          found_next = 1'b1;
          pos_next   = j;
          st_next    = ret;
        end else begin
          j_next  = j + ONE;
          st_next = bssa_pkg::S_SRCH_RD;
        end
      end
      bssa_pkg::S_INS_DONE: begin
        if (found) begin
          stat_next = bssa_pkg::STAT_PRESENT;
        end else begin
          wr_en   = 1'b1;
          wr_sel  = sel_mem;
          wr_addr = cnt_sel[AW-1:0];
          if (sel) cnt_b_next = cnt_b + ONE;
          else     cnt_a_next = cnt_a + ONE;
          stat_next = bssa_pkg::STAT_DONE;
        end
        st_next = bssa_pkg::S_RESP;
      end
      bssa_pkg::S_DEL_DONE: begin
        if (!found) begin
          stat_next = bssa_pkg::STAT_NOTFOUND;
          st_next   = bssa_pkg::S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_sel  = sel_mem;
          rd_addr = AW'(cnt_sel - ONE);
          st_next = bssa_pkg::S_DEL_WR;
        end
      end
      bssa_pkg::S_DEL_WR: begin
        // move the last entry into the freed slot
        wr_en   = 1'b1;
        wr_sel  = sel_mem;
        wr_addr = pos[AW-1:0];
        wr_data = rd_data;
        if (sel) cnt_b_next = cnt_b - ONE;
        else     cnt_a_next = cnt_a - ONE;
        stat_next = bssa_pkg::STAT_DONE;
        st_next   = bssa_pkg::S_RESP;
      end
      bssa_pkg::S_RESP: begin
        if (out_free) begin
          o_load   = 1'b1;
          o_status = stat;
          o_count  = 5'(cnt_sel);
          st_next  = bssa_pkg::S_IDLE;
        end
      end
      bssa_pkg::S_CPY_RD: begin
        if (i >= cnt_a) begin
          i_next  = '0;
          st_next = bssa_pkg::S_OUTER_RD;
        end else begin
          rd_en   = 1'b1;
          rd_sel  = bssa_pkg::MEM_A;
          rd_addr = i[AW-1:0];
          st_next = bssa_pkg::S_CPY_WR;
        end
      end
      bssa_pkg::S_CPY_WR: begin
        wr_en   = 1'b1;
        wr_sel  = bssa_pkg::MEM_S;
        wr_addr = i[AW-1:0];
        wr_data = rd_data;
        sc_next = sc + ONE;
        i_next  = i + ONE;
        st_next = bssa_pkg::S_CPY_RD;
      end
      bssa_pkg::S_OUTER_RD: begin
        if (i >= lim || (op == bssa_pkg::ACT_UNION && sc >= CAP)) begin
          i_next  = '0;
          st_next = bssa_pkg::S_EMIT_RD;
        end else begin
          rd_en   = 1'b1;
          rd_sel  = (op == bssa_pkg::ACT_UNION) ? bssa_pkg::MEM_B : bssa_pkg::MEM_A;
          rd_addr = i[AW-1:0];
          st_next = bssa_pkg::S_OUTER_KEY;
        end
      end
      bssa_pkg::S_OUTER_KEY: begin
        // union looks the B value up in A; the others look the A value up in B
        key_next = rd_data;
        j_next   = '0;
        ret_next = bssa_pkg::S_OUTER_DONE;
        if (op == bssa_pkg::ACT_UNION) begin
          srch_mem_next = bssa_pkg::MEM_A;
          srch_n_next   = cnt_a;
        end else begin
          srch_mem_next = bssa_pkg::MEM_B;
          srch_n_next   = cnt_b;
        end
        st_next = bssa_pkg::S_SRCH_RD;
      end
      bssa_pkg::S_OUTER_DONE: begin
        i_next  = i + ONE;
        st_next = bssa_pkg::S_OUTER_RD;
        if ((op == bssa_pkg::ACT_UNION && !found) || (op == bssa_pkg::ACT_INTER && found)) begin
          wr_en   = 1'b1;
          wr_sel  = bssa_pkg::MEM_S;
          wr_addr = sc[AW-1:0];
          sc_next = sc + ONE;
        end else if (op == bssa_pkg::ACT_DIFF && found) begin
          i_next        = i;
          j_next        = '0;
          srch_mem_next = bssa_pkg::MEM_S;
          srch_n_next   = sc;
          ret_next      = bssa_pkg::S_DIF_DONE;
          st_next       = bssa_pkg::S_SRCH_RD;
        end
      end
      bssa_pkg::S_DIF_DONE: begin
        if (found) begin
          rd_en   = 1'b1;
          rd_sel  = bssa_pkg::MEM_S;
          rd_addr = AW'(sc - ONE);
          st_next = bssa_pkg::S_DIF_WR;
        end else begin
          i_next  = i + ONE;
          st_next = bssa_pkg::S_OUTER_RD;
        end
      end
      bssa_pkg::S_DIF_WR: begin
        wr_en   = 1'b1;
        wr_sel  = bssa_pkg::MEM_S;
        wr_addr = pos[AW-1:0];
        wr_data = rd_data;
        sc_next = sc - ONE;
        i_next  = i + ONE;
        st_next = bssa_pkg::S_OUTER_RD;
      end
      bssa_pkg::S_EMIT_RD: begin
        if (sc == '0) begin
          // empty result: one beat marked invalid and last
          if (out_free) begin
            o_load  = 1'b1;
            st_next = bssa_pkg::S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_sel  = bssa_pkg::MEM_S;
          rd_addr = i[AW-1:0];
          st_next = bssa_pkg::S_EMIT_OUT;
        end
      end
      bssa_pkg::S_EMIT_OUT: begin
        if (out_free) begin
          o_load  = 1'b1;
          o_value = rd_data;
          o_valid = 1'b1;
          o_last  = ((i + ONE) == sc);
          o_count = 5'(sc);
          i_next  = i + ONE;
          st_next = ((i + ONE) == sc) ? bssa_pkg::S_IDLE : bssa_pkg::S_EMIT_RD;
        end
      end
      default: st_next = bssa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= bssa_pkg::S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  assign rd_mem_next = rd_en ? rd_sel : rd_mem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
      sc    <= '0;
    end else begin
      cnt_a <= cnt_a_next;
      cnt_b <= cnt_b_next;
      sc    <= sc_next;
    end
  end

  always_ff @(posedge clk) begin
    ret      <= ret_next;
    srch_mem <= srch_mem_next;
    rd_mem   <= rd_mem_next;
    op       <= op_next;
    sel      <= sel_next;
    key      <= key_next;
    i        <= i_next;
    j        <= j_next;
    pos      <= pos_next;
    srch_n   <= srch_n_next;
    found    <= found_next;
    stat     <= stat_next;
  end

  // output register: load a new beat, drop the old one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (o_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      result_value <= o_value;
      result_valid <= o_valid;
      last         <= o_last;
      status       <= o_status;
      result_count <= o_count;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_a <= CAP && cnt_b <= CAP && sc <= CAP)
    else $error("set size beyond capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !result_valid |-> last)
    else $error("status beat not marked last");

  a_algebra_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && result_valid |-> status == bssa_pkg::STAT_DONE)
    else $error("element beat with non-done status");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    o_load |-> out_free)
    else $error("output beat overwritten while stalled");

endmodule
